// ----- hw/rtl/ras_pkg.sv -----
package ras_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int PC_W        = 64;
  localparam int CNT_W       = 32;
  localparam int DEPTH_OUT_W = 5;
  localparam int CTR_NUM     = 7;

  typedef enum logic [1:0] {
    KIND_OTHER   = 2'd0,
    KIND_CALL    = 2'd1,
    KIND_RET     = 2'd2,
    KIND_RESTART = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_PLAIN    = 3'd0,
    ST_PUSH     = 3'd1,
    ST_PUSH_OVF = 3'd2,
    ST_HIT      = 3'd3,
    ST_MISS     = 3'd4,
    ST_UNDER    = 3'd5,
    ST_RESTART  = 3'd6
  } status_t;

  // Positions of the event counters in the counter bank.
  localparam int CTR_BLOCK = 0;
  localparam int CTR_PUSH  = 1;
  localparam int CTR_POP   = 2;
  localparam int CTR_OVF   = 3;
  localparam int CTR_UNDER = 4;
  localparam int CTR_HIT   = 5;
  localparam int CTR_MISS  = 6;

  typedef struct packed {
    logic            clear;
    logic            push;
    logic            pop;
    logic [PC_W-1:0] push_pc;
  } stk_ctl_t;

  typedef struct packed {
    logic clear;
    logic block;
    logic push;
    logic pop;
    logic ovf;
    logic under;
    logic hit;
    logic miss;
  } ctr_ctl_t;

endpackage

// ----- hw/rtl/return_address_stack_predictor_unit.sv -----
// Each event passes through the input register, then the result register,
// which is written together with the stack and counters.
// Throughput: one event per cycle unless out_stall holds the result; the stack update per event sets it.
// Reset clears the stack depth, all counters and both valid flags; stack
// entries are not cleared and are only read after a push has written them.
module return_address_stack_predictor_unit
  import ras_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_kind,
  input  logic [PC_W-1:0]        in_return_pc,
  input  logic [PC_W-1:0]        in_next_pc,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [2:0]             out_status,
  output logic [PC_W-1:0]        out_predicted_pc,
  output logic [DEPTH_OUT_W-1:0] out_stack_depth,
  output logic [CNT_W-1:0]       out_block_count,
  output logic [CNT_W-1:0]       out_push_count,
  output logic [CNT_W-1:0]       out_pop_count,
  output logic [CNT_W-1:0]       out_overflow_count,
  output logic [CNT_W-1:0]       out_underflow_count,
  output logic [CNT_W-1:0]       out_hit_count,
  output logic [CNT_W-1:0]       out_miss_count
);

  logic            s1_valid_r;
  kind_t           s1_kind_r;
  logic [PC_W-1:0] s1_ret_r;
  logic [PC_W-1:0] s1_next_r;

  logic            out_valid_r;
  status_t         status_r;
  status_t         status_nxt;
  logic [PC_W-1:0] predicted_r;
  logic [PC_W-1:0] predicted_nxt;

  logic               out_free;
  logic               adv;
  stk_ctl_t           stk_ctl;
  ctr_ctl_t           ctr_ctl;
  logic [DEPTH_W-1:0] depth;
  logic               full;
  logic               empty;
  logic [PC_W-1:0]    top_pc;
  logic               hit;

  // The stack and counters are written only when an event moves into the
  // result register, so their outputs hold the result's state until then.
  assign out_free = !out_valid_r || !out_stall;
  assign adv      = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign hit      = (top_pc == s1_next_r);

  always_comb begin
    stk_ctl         = '0;
    stk_ctl.push_pc = s1_ret_r;
    ctr_ctl         = '0;
    status_nxt      = ST_PLAIN;
    predicted_nxt   = '0;
    case (s1_kind_r)
      KIND_RESTART: begin
        stk_ctl.clear = adv;
        ctr_ctl.clear = adv;
        status_nxt    = ST_RESTART;
      end
      KIND_CALL: begin
        stk_ctl.push  = adv;
        ctr_ctl.block = adv;
        ctr_ctl.push  = adv;
        ctr_ctl.ovf   = adv && full;
        status_nxt    = full ? ST_PUSH_OVF : ST_PUSH;
      end
      KIND_RET: begin
        ctr_ctl.block = adv;
        ctr_ctl.pop   = adv;
        if (empty) begin
          ctr_ctl.under = adv;
          status_nxt    = ST_UNDER;
        end else begin
          stk_ctl.pop   = adv;
          predicted_nxt = top_pc;
          ctr_ctl.hit   = adv && hit;
          ctr_ctl.miss  = adv && !hit;
          status_nxt    = hit ? ST_HIT : ST_MISS;
        end
      end
      default: begin
        ctr_ctl.block = adv;
      end
    endcase
  end

  ras_stack u_stack (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (stk_ctl),
    .depth  (depth),
    .full   (full),
    .empty  (empty),
    .top_pc (top_pc)
  );

  ras_ctrs u_ctrs (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctr_ctl),
    .block_count     (out_block_count),
    .push_count      (out_push_count),
    .pop_count       (out_pop_count),
    .overflow_count  (out_overflow_count),
    .underflow_count (out_underflow_count),
    .hit_count       (out_hit_count),
    .miss_count      (out_miss_count)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_kind_r <= kind_t'(in_kind);
      s1_ret_r  <= in_return_pc;
      s1_next_r <= in_next_pc;
    end
    if (adv) begin
      status_r    <= status_nxt;
      predicted_r <= predicted_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_predicted_pc = predicted_r;
  assign out_stack_depth  = DEPTH_OUT_W'(depth);

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth <= DEPTH_W'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r == ST_RESTART)) |->
      (depth == '0) && (out_block_count == '0) && (predicted_r == '0))
    else $error("restart result does not show a cleared run");

  a_held_item: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && out_stall) |=>
      s1_valid_r && $stable(s1_kind_r) && $stable(s1_ret_r) && $stable(depth))
    else $error("pending event or stack changed while the result is held");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    stk_ctl.pop |-> !empty && !stk_ctl.push)
    else $error("pop issued on an empty stack or together with a push");
`endif

endmodule

// ----- hw/rtl/ras_stack.sv -----
module ras_stack
  import ras_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  stk_ctl_t           ctl,
  output logic [DEPTH_W-1:0] depth,
  output logic               full,
  output logic               empty,
  output logic [PC_W-1:0]    top_pc
);

  logic [PC_W-1:0]    entry_r [STACK_DEPTH];
  logic [DEPTH_W-1:0] depth_r;
  logic [DEPTH_W-1:0] depth_nxt;
  logic [PTR_W-1:0]   wr_idx;
  logic [PTR_W-1:0]   rd_idx;

  assign full   = (depth_r == DEPTH_W'(STACK_DEPTH));
  assign empty  = (depth_r == '0);
  assign depth  = depth_r;
  assign rd_idx = PTR_W'(depth_r - DEPTH_W'(1));
  // On a full stack the top slot is overwritten in place.
  assign wr_idx = full ? PTR_W'(STACK_DEPTH - 1) : PTR_W'(depth_r);
  assign top_pc = entry_r[rd_idx];

  always_comb begin
    depth_nxt = depth_r;
    if (ctl.clear) begin
      depth_nxt = '0;
    end else if (ctl.push && !full) begin
      depth_nxt = depth_r + DEPTH_W'(1);
    end else if (ctl.pop && !empty) begin
      depth_nxt = depth_r - DEPTH_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else begin
      depth_r <= depth_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      entry_r[wr_idx] <= ctl.push_pc;
    end
  end

endmodule

// ----- hw/rtl/ras_ctrs.sv -----
module ras_ctrs
  import ras_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  ctr_ctl_t         ctl,
  output logic [CNT_W-1:0] block_count,
  output logic [CNT_W-1:0] push_count,
  output logic [CNT_W-1:0] pop_count,
  output logic [CNT_W-1:0] overflow_count,
  output logic [CNT_W-1:0] underflow_count,
  output logic [CNT_W-1:0] hit_count,
  output logic [CNT_W-1:0] miss_count
);

  logic [CNT_W-1:0]   cnt_r [CTR_NUM];
  logic [CTR_NUM-1:0] inc;

  always_comb begin
    inc            = '0;
    inc[CTR_BLOCK] = ctl.block;
    inc[CTR_PUSH]  = ctl.push;
    inc[CTR_POP]   = ctl.pop;
    inc[CTR_OVF]   = ctl.ovf;
    inc[CTR_UNDER] = ctl.under;
    inc[CTR_HIT]   = ctl.hit;
    inc[CTR_MISS]  = ctl.miss;
  end

  // Each counter sticks at all ones once it gets there.
  always_ff @(posedge clk) begin
    for (int i = 0; i < CTR_NUM; i++) begin
      if (!rst_n || ctl.clear) begin
        cnt_r[i] <= '0;
      end else if (inc[i] && (cnt_r[i] != '1)) begin
        cnt_r[i] <= cnt_r[i] + CNT_W'(1);
      end
    end
  end

  assign block_count     = cnt_r[CTR_BLOCK];
  assign push_count      = cnt_r[CTR_PUSH];
  assign pop_count       = cnt_r[CTR_POP];
  assign overflow_count  = cnt_r[CTR_OVF];
  assign underflow_count = cnt_r[CTR_UNDER];
  assign hit_count       = cnt_r[CTR_HIT];
  assign miss_count      = cnt_r[CTR_MISS];

endmodule

// ----- bench/ras_event_checker.sv -----
module ras_event_checker
  import ras_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [1:0]             in_kind,
  input  logic [PC_W-1:0]        in_return_pc,
  input  logic [PC_W-1:0]        in_next_pc,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [2:0]             out_status,
  input  logic [PC_W-1:0]        out_predicted_pc,
  input  logic [DEPTH_OUT_W-1:0] out_stack_depth,
  input  logic [CNT_W-1:0]       out_block_count,
  input  logic [CNT_W-1:0]       out_push_count,
  input  logic [CNT_W-1:0]       out_pop_count,
  input  logic [CNT_W-1:0]       out_overflow_count,
  input  logic [CNT_W-1:0]       out_underflow_count,
  input  logic [CNT_W-1:0]       out_hit_count,
  input  logic [CNT_W-1:0]       out_miss_count,
  output int                     fail_count,
  output int                     pending,
  output int                     hits_seen,
  output int                     misses_seen,
  output int                     overflows_seen,
  output int                     underflows_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t                           status;
    logic [PC_W-1:0]                   predicted_pc;
    logic [DEPTH_OUT_W-1:0]            depth;
    logic [CTR_NUM-1:0][CNT_W-1:0]     counts;
  } event_outcome_t;

  event_outcome_t                outcome_q [$];
  logic [PC_W-1:0]               ret_stack [STACK_DEPTH];
  int unsigned                   stack_fill;
  logic [CTR_NUM-1:0][CNT_W-1:0] tally;

  initial begin
    fail_count      = 0;
    pending         = 0;
    hits_seen       = 0;
    misses_seen     = 0;
    overflows_seen  = 0;
    underflows_seen = 0;
    stack_fill      = 0;
    tally           = '0;
  end

  function automatic void bump(input int idx);
    if (tally[idx] != '1) begin
      tally[idx] = tally[idx] + CNT_W'(1);
    end
  endfunction

  task automatic predict_outcome(input kind_t k, input logic [PC_W-1:0] ret_pc,
                                 input logic [PC_W-1:0] obs_pc);
    event_outcome_t o;
    o.status       = ST_PLAIN;
    o.predicted_pc = '0;
    if (k == KIND_RESTART) begin
      // The stack contents survive a restart but become unreachable.
      stack_fill = 0;
      tally      = '0;
      o.status   = ST_RESTART;
    end else begin
      case (k)
        KIND_CALL: begin
          bump(CTR_PUSH);
          if (stack_fill >= STACK_DEPTH) begin
            ret_stack[STACK_DEPTH-1] = ret_pc;
            bump(CTR_OVF);
            o.status = ST_PUSH_OVF;
          end else begin
            ret_stack[stack_fill] = ret_pc;
            stack_fill++;
            o.status = ST_PUSH;
          end
        end
        KIND_RET: begin
          bump(CTR_POP);
          if (stack_fill == 0) begin
            bump(CTR_UNDER);
            o.status = ST_UNDER;
          end else begin
            stack_fill--;
            o.predicted_pc = ret_stack[stack_fill];
            if (o.predicted_pc == obs_pc) begin
              bump(CTR_HIT);
              o.status = ST_HIT;
            end else begin
              bump(CTR_MISS);
              o.status = ST_MISS;
            end
          end
        end
        default: ;
      endcase
      bump(CTR_BLOCK);
    end
    o.depth  = DEPTH_OUT_W'(stack_fill);
    o.counts = tally;
    outcome_q.push_back(o);
  endtask

  task automatic check_field(input string name, input logic [PC_W-1:0] want_v,
                             input logic [PC_W-1:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    event_outcome_t want;
    if (!rst_n) begin
      stack_fill = 0;
      tally      = '0;
      outcome_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: result transfer with no event outstanding, status %0d",
                   $time, out_status);
          fail_count++;
        end else begin
          want = outcome_q.pop_front();
          check_field("status", 64'(want.status), 64'(out_status));
          check_field("predicted_pc", want.predicted_pc, out_predicted_pc);
          check_field("stack_depth", 64'(want.depth), 64'(out_stack_depth));
          check_field("block_count", 64'(want.counts[CTR_BLOCK]), 64'(out_block_count));
          check_field("push_count", 64'(want.counts[CTR_PUSH]), 64'(out_push_count));
          check_field("pop_count", 64'(want.counts[CTR_POP]), 64'(out_pop_count));
          check_field("overflow_count", 64'(want.counts[CTR_OVF]),
                      64'(out_overflow_count));
          check_field("underflow_count", 64'(want.counts[CTR_UNDER]),
                      64'(out_underflow_count));
          check_field("hit_count", 64'(want.counts[CTR_HIT]), 64'(out_hit_count));
          check_field("miss_count", 64'(want.counts[CTR_MISS]), 64'(out_miss_count));
          case (want.status)
            ST_HIT:      hits_seen++;
            ST_MISS:     misses_seen++;
            ST_PUSH_OVF: overflows_seen++;
            ST_UNDER:    underflows_seen++;
            default: ;
          endcase
        end
      end
      // A result never leaves in the same cycle as its own event is taken in.
      if (in_valid && !in_stall) begin
        predict_outcome(kind_t'(in_kind), in_return_pc, in_next_pc);
      end
    end
    pending = outcome_q.size();
  end

endmodule

// ----- bench/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ras_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 180;
  localparam int LONG_HOLD   = 60;
  localparam int DRAIN_WAIT  = 10;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [1:0]             in_kind;
  logic [PC_W-1:0]        in_return_pc;
  logic [PC_W-1:0]        in_next_pc;
  logic                   out_valid;
  logic                   out_stall;
  logic [2:0]             out_status;
  logic [PC_W-1:0]        out_predicted_pc;
  logic [DEPTH_OUT_W-1:0] out_stack_depth;
  logic [CNT_W-1:0]       out_block_count;
  logic [CNT_W-1:0]       out_push_count;
  logic [CNT_W-1:0]       out_pop_count;
  logic [CNT_W-1:0]       out_overflow_count;
  logic [CNT_W-1:0]       out_underflow_count;
  logic [CNT_W-1:0]       out_hit_count;
  logic [CNT_W-1:0]       out_miss_count;

  int fail_count;
  int pending;
  int hits_seen;
  int misses_seen;
  int overflows_seen;
  int underflows_seen;

  int              snd_idle_pct = 0;
  int              rcv_idle_pct = 0;
  int              hold_left    = 0;
  int              cycles       = 0;
  int              kind_count [4];
  logic [PC_W-1:0] shadow [$];

  return_address_stack_predictor_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_kind             (in_kind),
    .in_return_pc        (in_return_pc),
    .in_next_pc          (in_next_pc),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_predicted_pc    (out_predicted_pc),
    .out_stack_depth     (out_stack_depth),
    .out_block_count     (out_block_count),
    .out_push_count      (out_push_count),
    .out_pop_count       (out_pop_count),
    .out_overflow_count  (out_overflow_count),
    .out_underflow_count (out_underflow_count),
    .out_hit_count       (out_hit_count),
    .out_miss_count      (out_miss_count)
  );

  ras_event_checker checker_i (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_kind             (in_kind),
    .in_return_pc        (in_return_pc),
    .in_next_pc          (in_next_pc),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_predicted_pc    (out_predicted_pc),
    .out_stack_depth     (out_stack_depth),
    .out_block_count     (out_block_count),
    .out_push_count      (out_push_count),
    .out_pop_count       (out_pop_count),
    .out_overflow_count  (out_overflow_count),
    .out_underflow_count (out_underflow_count),
    .out_hit_count       (out_hit_count),
    .out_miss_count      (out_miss_count),
    .fail_count          (fail_count),
    .pending             (pending),
    .hits_seen           (hits_seen),
    .misses_seen         (misses_seen),
    .overflows_seen      (overflows_seen),
    .underflows_seen     (underflows_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.", cycles, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side: random stalls, or a long hold-off when one is requested.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
    end
  end

  // Offers one event and returns at the falling edge after its transfer.
  task automatic issue(input kind_t k, input logic [PC_W-1:0] ret_pc,
                       input logic [PC_W-1:0] nxt_pc);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= k;
    in_return_pc <= ret_pc;
    in_next_pc   <= nxt_pc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    kind_count[k]++;
    case (k)
      KIND_CALL: begin
        if (shadow.size() == STACK_DEPTH) begin
          shadow[STACK_DEPTH-1] = ret_pc;
        end else begin
          shadow.push_back(ret_pc);
        end
      end
      KIND_RET: begin
        if (shadow.size() > 0) void'(shadow.pop_back());
      end
      KIND_RESTART: shadow.delete();
      default: ;
    endcase
  endtask

  // Returns mostly land on the address the matching call pushed.
  task automatic random_event(input int call_pct);
    logic [PC_W-1:0] ret_pc;
    logic [PC_W-1:0] nxt_pc;
    int              r;
    kind_t           k;
    ret_pc = {$urandom, $urandom};
    nxt_pc = {$urandom, $urandom};
    r = $urandom_range(99);
    if (r < 2) begin
      k = KIND_RESTART;
    end else if (r < 10) begin
      k = KIND_OTHER;
    end else if (r < 10 + call_pct) begin
      k = KIND_CALL;
    end else begin
      k = KIND_RET;
    end
    if (k == KIND_RET && shadow.size() > 0) begin
      case ($urandom_range(9))
        0: ;
        1: nxt_pc = shadow[$] ^ (64'd1 << $urandom_range(63));
        default: nxt_pc = shadow[$];
      endcase
    end
    issue(k, ret_pc, nxt_pc);
  endtask

  task automatic quiet_until_drained();
    in_valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  task automatic run_phase(input int snd_pct, input int rcv_pct, input bit long_hold);
    int call_pct;
    call_pct     = 45;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      // Swing the call mix so the stack both fills to overflow and drains to empty.
      if (i % 40 == 0) begin
        case ($urandom_range(2))
          0: call_pct = 25;
          1: call_pct = 45;
          default: call_pct = 70;
        endcase
      end
      if (long_hold && i == 60) hold_left = LONG_HOLD;
      random_event(call_pct);
    end
  endtask

  initial begin
    in_valid     = 1'b0;
    in_kind      = KIND_OTHER;
    in_return_pc = '0;
    in_next_pc   = '0;
    rst_n        = 1'b0;
    foreach (kind_count[i]) kind_count[i] = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    snd_idle_pct = 10;
    rcv_idle_pct = 10;
    issue(KIND_OTHER, '0, '0);
    issue(KIND_RET, '1, '1);
    issue(KIND_CALL, '1, '0);
    issue(KIND_CALL, '0, '1);
    issue(KIND_RET, '0, '0);
    issue(KIND_RET, '0, '0);
    // One call more than the stack holds, so the last one overwrites the top.
    for (int i = 0; i < STACK_DEPTH + 1; i++) begin
      issue(KIND_CALL, {$urandom, $urandom}, '0);
    end
    issue(KIND_RET, '0, shadow[$]);
    issue(KIND_RESTART, '1, '1);
    issue(KIND_RET, '0, '0);
    quiet_until_drained();

    run_phase(19, 49, 1'b1);
    quiet_until_drained();
    run_phase(49, 19, 1'b0);
    quiet_until_drained();
    run_phase(0, 0, 1'b0);

    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d events: %0d other, %0d calls, %0d returns, %0d restarts.",
             kind_count[KIND_OTHER] + kind_count[KIND_CALL] + kind_count[KIND_RET] +
             kind_count[KIND_RESTART], kind_count[KIND_OTHER], kind_count[KIND_CALL],
             kind_count[KIND_RET], kind_count[KIND_RESTART]);
    $display("Returns hit %0d and missed %0d; %0d overflows, %0d underflows, %0d errors.",
             hits_seen, misses_seen, overflows_seen, underflows_seen, fail_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/ras_pkg.sv
hw/rtl/ras_stack.sv
hw/rtl/ras_ctrs.sv
hw/rtl/return_address_stack_predictor_unit.sv
bench/ras_event_checker.sv
bench/testbench.sv
